[sv/csac_pkg.sv]
// ----------------------------------------------------------------------------
// csac_pkg
// shared constants, codes and control bundles of the call sequence checker
// ----------------------------------------------------------------------------
package csac_pkg;

    localparam int MAX_NODES    = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int CALL_ID_BITS = 16;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int NODE_W   = 8;
    localparam int NODE_IDX_W  = $clog2(MAX_NODES);
    localparam int NODE_CNT_W  = $clog2(MAX_NODES + 1);
    localparam int EDGE_IDX_W  = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W      = NODE_W + CALL_ID_BITS;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_NODE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FINALIZE   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET      = 3'd4;
    localparam logic [OP_W-1:0] OP_TRANSITION = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ORDER     = 3'd5;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_start;
        logic scan_done;
    } t_dp_stat;

endpackage

[sv/csac_ctrl.sv]
// ----------------------------------------------------------------------------
// csac_ctrl
// item sequencer: accept, execute, edge scan, result hold
// ----------------------------------------------------------------------------
module csac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  csac_pkg::t_dp_stat i_stat,
    output csac_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.scan_start ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/csac_dp.sv]
// ----------------------------------------------------------------------------
// csac_dp
// graph tables, load counters, automaton state and edge scan datapath
// ----------------------------------------------------------------------------
module csac_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csac_pkg::t_dp_cmd                   i_cmd,
    output csac_pkg::t_dp_stat                  o_stat,
    input  logic [csac_pkg::OP_W-1:0]           i_opcode,
    input  logic [csac_pkg::NODE_W-1:0]         i_node_id,
    input  logic [csac_pkg::CALL_ID_BITS-1:0]   i_call_id,
    input  logic [csac_pkg::NODE_W-1:0]         i_next_state,
    output logic [csac_pkg::STATUS_W-1:0]       o_status,
    output logic [csac_pkg::NODE_W-1:0]         o_current_state
);

    // captured item
    logic [csac_pkg::OP_W-1:0]         r_op;
    logic [csac_pkg::NODE_W-1:0]       r_node_id;
    logic [csac_pkg::CALL_ID_BITS-1:0] r_call;
    logic [csac_pkg::NODE_W-1:0]       r_next;

    // control state
    logic [csac_pkg::NODE_CNT_W-1:0] r_nodes, n_nodes;
    logic [csac_pkg::EDGE_CNT_W-1:0] r_edges, n_edges;
    logic [csac_pkg::EDGE_CNT_W-1:0] r_last_total, n_last_total;
    logic                            r_ready, n_ready;
    logic [csac_pkg::NODE_W-1:0]     r_present, n_present;
    logic [csac_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [csac_pkg::EDGE_CNT_W-1:0] r_idx, n_idx;
    logic [csac_pkg::EDGE_CNT_W-1:0] r_left, n_left;
    logic                            r_pend, n_pend;

    // memories
    logic [csac_pkg::EDGE_IDX_W-1:0] r_start_mem [csac_pkg::MAX_NODES];
    logic [csac_pkg::EDGE_CNT_W-1:0] r_total_mem [csac_pkg::MAX_NODES];
    logic [csac_pkg::EDGE_W-1:0]     r_edge_mem  [csac_pkg::MAX_EDGES];
    logic [csac_pkg::EDGE_IDX_W-1:0] r_start_q;
    logic [csac_pkg::EDGE_CNT_W-1:0] r_total_q;
    logic [csac_pkg::EDGE_W-1:0]     r_edge_q;

    logic                            start_we;
    logic                            total_we;
    logic [csac_pkg::NODE_IDX_W-1:0] start_addr;
    logic [csac_pkg::NODE_IDX_W-1:0] total_addr;
    logic [csac_pkg::EDGE_CNT_W-1:0] total_wdata;
    logic                            edge_we;

    logic                            hit;
    logic [csac_pkg::NODE_W-1:0]     hit_target;
    logic                            can_issue;
    logic [csac_pkg::NODE_CNT_W-1:0] newest_node;

    assign hit        = r_pend && (r_edge_q[csac_pkg::CALL_ID_BITS-1:0] == r_call);
    assign hit_target = r_edge_q[csac_pkg::EDGE_W-1:csac_pkg::CALL_ID_BITS];
    assign can_issue  = (r_left != '0) &&
                        (r_idx < csac_pkg::EDGE_CNT_W'(csac_pkg::MAX_EDGES));
    assign newest_node = r_nodes - csac_pkg::NODE_CNT_W'(1);

    always_comb begin
        n_nodes      = r_nodes;
        n_edges      = r_edges;
        n_last_total = r_last_total;
        n_ready      = r_ready;
        n_present    = r_present;
        n_status     = r_status;
        n_idx        = r_idx;
        n_left       = r_left;
        n_pend       = r_pend;
        start_we     = 1'b0;
        total_we     = 1'b0;
        edge_we      = 1'b0;
        start_addr   = r_node_id[csac_pkg::NODE_IDX_W-1:0];
        total_addr   = r_node_id[csac_pkg::NODE_IDX_W-1:0];
        total_wdata  = '0;
        o_stat       = '0;

        if (i_cmd.exec) begin
            n_status = csac_pkg::ST_OK;
            unique case (r_op)
                csac_pkg::OP_CLEAR: begin
                    n_nodes   = '0;
                    n_edges   = '0;
                    n_ready   = 1'b0;
                    n_present = '0;
                end
                csac_pkg::OP_ADD_NODE: begin
                    if (r_ready) begin
                        n_status = csac_pkg::ST_ORDER;
                    end else if (r_nodes >= csac_pkg::NODE_CNT_W'(csac_pkg::MAX_NODES)) begin
                        n_status = csac_pkg::ST_FULL;
                    end else if (csac_pkg::NODE_CNT_W'(r_node_id) != r_nodes) begin
                        n_status = csac_pkg::ST_ORDER;
                    end else begin
                        start_we     = 1'b1;
                        total_we     = 1'b1;
                        n_last_total = '0;
                        n_nodes      = r_nodes + csac_pkg::NODE_CNT_W'(1);
                    end
                end
                csac_pkg::OP_ADD_EDGE: begin
                    if (r_ready || r_nodes == '0) begin
                        n_status = csac_pkg::ST_ORDER;
                    end else if (r_edges >= csac_pkg::EDGE_CNT_W'(csac_pkg::MAX_EDGES)) begin
                        n_status = csac_pkg::ST_FULL;
                    end else begin
                        edge_we      = 1'b1;
                        total_we     = 1'b1;
                        total_addr   = newest_node[csac_pkg::NODE_IDX_W-1:0];
                        total_wdata  = r_last_total + csac_pkg::EDGE_CNT_W'(1);
                        n_last_total = total_wdata;
                        n_edges      = r_edges + csac_pkg::EDGE_CNT_W'(1);
                    end
                end
                csac_pkg::OP_FINALIZE: begin
                    n_ready = 1'b1;
                end
                csac_pkg::OP_RESET: begin
                    if (!r_ready) begin
                        n_status = csac_pkg::ST_NOT_READY;
                    end else begin
                        n_present = '0;
                    end
                end
                csac_pkg::OP_TRANSITION: begin
                    if (!r_ready) begin
                        n_status = csac_pkg::ST_NOT_READY;
                    end else if (csac_pkg::NODE_CNT_W'(r_present) >= r_nodes) begin
                        n_status = csac_pkg::ST_BAD_STATE;
                    end else begin
                        // node table data for the present node is already registered
                        o_stat.scan_start = 1'b1;
                        n_idx  = csac_pkg::EDGE_CNT_W'(r_start_q);
                        n_left = r_total_q;
                        n_pend = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.scan) begin
            // compare the entry read last cycle while the next one is fetched
            if (hit) begin
                o_stat.scan_done = 1'b1;
                n_pend = 1'b0;
                if (hit_target == '0) begin
                    n_status = csac_pkg::ST_NO_MATCH;
                end else begin
                    n_status  = csac_pkg::ST_OK;
                    n_present = hit_target;
                end
            end else if (can_issue) begin
                n_pend = 1'b1;
                n_idx  = r_idx + csac_pkg::EDGE_CNT_W'(1);
                n_left = r_left - csac_pkg::EDGE_CNT_W'(1);
            end else begin
                o_stat.scan_done = 1'b1;
                n_pend   = 1'b0;
                n_status = csac_pkg::ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes   <= '0;
            r_edges   <= '0;
            r_ready   <= 1'b0;
            r_present <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_nodes   <= n_nodes;
            r_edges   <= n_edges;
            r_ready   <= n_ready;
            r_present <= n_present;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_total <= n_last_total;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_left       <= n_left;
        if (i_cmd.capture) begin
            r_op      <= i_opcode;
            r_node_id <= i_node_id;
            r_call    <= i_call_id;
            r_next    <= i_next_state;
        end
    end

    // node tables, read at the present node every cycle
    always_ff @(posedge i_clk) begin
        if (start_we) begin
            r_start_mem[start_addr] <= r_edges[csac_pkg::EDGE_IDX_W-1:0];
        end
        r_start_q <= r_start_mem[r_present[csac_pkg::NODE_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (total_we) begin
            r_total_mem[total_addr] <= total_wdata;
        end
        r_total_q <= r_total_mem[r_present[csac_pkg::NODE_IDX_W-1:0]];
    end

    // edge table, read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_edges[csac_pkg::EDGE_IDX_W-1:0]] <= {r_next, r_call};
        end
        r_edge_q <= r_edge_mem[r_idx[csac_pkg::EDGE_IDX_W-1:0]];
    end

    assign o_status        = r_status;
    assign o_current_state = r_present;

endmodule

[sv/call_sequence_automaton_checker.sv]
// ----------------------------------------------------------------------------
// call_sequence_automaton_checker
// checks call ids against a loaded edge-list automaton, one result per item
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready | i_opcode i_node_id i_call_id i_next_state
//  out     | o_out_valid/ i_out_ready| o_status o_current_state
//
//  load, control and refused items pass through the execute and result states, with no edge scan
//  a transition that scans edges also passes through the edge scan state (one edge table read per cycle)
//  one item at a time: the next input transfer follows the result transfer
//  synchronous active-low reset empties the graph; no clearing pass is needed
//  a stalled result holds until taken
// ----------------------------------------------------------------------------
module call_sequence_automaton_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [csac_pkg::OP_W-1:0]         i_opcode,
    input  logic [csac_pkg::NODE_W-1:0]       i_node_id,
    input  logic [csac_pkg::CALL_ID_BITS-1:0] i_call_id,
    input  logic [csac_pkg::NODE_W-1:0]       i_next_state,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [csac_pkg::STATUS_W-1:0]     o_status,
    output logic [csac_pkg::NODE_W-1:0]       o_current_state
);

    csac_pkg::t_dp_cmd  cmd;
    csac_pkg::t_dp_stat stat;

    csac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    csac_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_node_id       (i_node_id),
        .i_call_id       (i_call_id),
        .i_next_state    (i_next_state),
        .o_status        (o_status),
        .o_current_state (o_current_state)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input open while a result is held");

    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready && !o_out_valid)
        else $error("transfer not followed by execute cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= csac_pkg::ST_ORDER))
        else $error("undefined status code");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == csac_pkg::ST_NOT_READY) |-> $stable(o_current_state))
        else $error("current state moved on a not-ready item");
`endif

endmodule

[test/tb_call_sequence_automaton_checker.sv]
// ----------------------------------------------------------------------------
// tb_call_sequence_automaton_checker
// self-checking bench: builds graphs, walks them with call ids, scores results
// ----------------------------------------------------------------------------
// Items go out from a queue with random gaps. Each accepted item runs through a
// local automaton model that keeps its own node and edge tables. The model's
// verdict (status and current node) is queued and matched against every
// result that the block hands back. The stimulus has a short directed list of
// corner cases, random sessions that build a small graph, finalize it and walk
// it, and one pass that fills the node table to the limit.
// ----------------------------------------------------------------------------
module tb_call_sequence_automaton_checker;

    localparam logic [csac_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [csac_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FIRST_ITEMS  = 300;
    localparam int TOTAL_ITEMS  = 950;
    localparam int IDLE_PCT     = 32;

    typedef struct packed {
        logic [csac_pkg::OP_W-1:0]         opcode;
        logic [csac_pkg::NODE_W-1:0]       node_id;
        logic [csac_pkg::CALL_ID_BITS-1:0] call_id;
        logic [csac_pkg::NODE_W-1:0]       next_state;
        logic                              hold;      // wait for all results before sending
    } t_call_item;

    typedef struct packed {
        logic [csac_pkg::STATUS_W-1:0] status;
        logic [csac_pkg::NODE_W-1:0]   node;
    } t_verdict;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [csac_pkg::OP_W-1:0]         opcode = csac_pkg::OP_CLEAR;
    logic [csac_pkg::NODE_W-1:0]       node_id = '0;
    logic [csac_pkg::CALL_ID_BITS-1:0] call_id = '0;
    logic [csac_pkg::NODE_W-1:0]       next_state = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [csac_pkg::STATUS_W-1:0]     status;
    logic [csac_pkg::NODE_W-1:0]       current_state;

    t_call_item call_q[$];
    t_verdict   verdict_q[$];
    int         n_queued = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         errors = 0;
    int         cycles = 0;
    logic       calm;

    // automaton model
    logic [csac_pkg::EDGE_CNT_W-1:0]   m_first [csac_pkg::MAX_NODES];
    logic [csac_pkg::EDGE_CNT_W-1:0]   m_count [csac_pkg::MAX_NODES];
    logic [csac_pkg::CALL_ID_BITS-1:0] m_edge_call [csac_pkg::MAX_EDGES];
    logic [csac_pkg::NODE_W-1:0]       m_edge_dest [csac_pkg::MAX_EDGES];
    int                                m_nodes = 0;
    int                                m_edges = 0;
    bit                                m_ready = 1'b0;
    logic [csac_pkg::NODE_W-1:0]       m_here = '0;

    call_sequence_automaton_checker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_node_id       (node_id),
        .i_call_id       (call_id),
        .i_next_state    (next_state),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_current_state (current_state)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // no idling on either side through this stretch
    assign calm = (items_sent >= 300) && (items_sent < 560);

    function automatic t_verdict advance_automaton(t_call_item it);
        t_verdict v;
        int idx;
        bit hit;
        v.status = csac_pkg::ST_OK;
        hit = 1'b0;
        case (it.opcode)
            csac_pkg::OP_CLEAR: begin
                m_nodes = 0;
                m_edges = 0;
                m_ready = 1'b0;
                m_here = '0;
            end
            csac_pkg::OP_ADD_NODE: begin
                if (m_ready) begin
                    v.status = csac_pkg::ST_ORDER;
                end else if (m_nodes >= csac_pkg::MAX_NODES) begin
                    v.status = csac_pkg::ST_FULL;
                end else if (int'(it.node_id) != m_nodes) begin
                    v.status = csac_pkg::ST_ORDER;
                end else begin
                    m_first[m_nodes] = csac_pkg::EDGE_CNT_W'(m_edges);
                    m_count[m_nodes] = '0;
                    m_nodes++;
                end
            end
            csac_pkg::OP_ADD_EDGE: begin
                if (m_ready || m_nodes == 0) begin
                    v.status = csac_pkg::ST_ORDER;
                end else if (m_edges >= csac_pkg::MAX_EDGES) begin
                    v.status = csac_pkg::ST_FULL;
                end else begin
                    m_edge_call[m_edges] = it.call_id;
                    m_edge_dest[m_edges] = it.next_state;
                    m_edges++;
                    m_count[m_nodes-1] = m_count[m_nodes-1] + csac_pkg::EDGE_CNT_W'(1);
                end
            end
            csac_pkg::OP_FINALIZE: begin
                m_ready = 1'b1;
            end
            csac_pkg::OP_RESET: begin
                if (!m_ready) v.status = csac_pkg::ST_NOT_READY;
                else m_here = '0;
            end
            csac_pkg::OP_TRANSITION: begin
                if (!m_ready) begin
                    v.status = csac_pkg::ST_NOT_READY;
                end else if (int'(m_here) >= m_nodes) begin
                    v.status = csac_pkg::ST_BAD_STATE;
                end else begin
                    v.status = csac_pkg::ST_NO_MATCH;
                    // first matching edge decides, a target of node 0 refuses
                    for (int i = 0; i < int'(m_count[m_here]); i++) begin
                        idx = int'(m_first[m_here]) + i;
                        if (!hit && m_edge_call[idx] == it.call_id) begin
                            hit = 1'b1;
                            if (m_edge_dest[idx] != '0) begin
                                m_here = m_edge_dest[idx];
                                v.status = csac_pkg::ST_OK;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        v.node = m_here;
        return v;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic queue_item(logic [csac_pkg::OP_W-1:0] op, logic [csac_pkg::NODE_W-1:0] id,
                              logic [csac_pkg::CALL_ID_BITS-1:0] call,
                              logic [csac_pkg::NODE_W-1:0] dest, bit hold = 1'b0);
        t_call_item it;
        it.opcode = op;
        it.node_id = id;
        it.call_id = call;
        it.next_state = dest;
        it.hold = hold;
        call_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_noise();
        queue_item(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // a small graph with random content, finalized and then walked
    task automatic queue_session();
        logic [csac_pkg::CALL_ID_BITS-1:0] pool [8];
        int pool_n;
        int graph_nodes;
        int fanout;
        int steps;
        int roll;
        logic [csac_pkg::NODE_W-1:0] dest;
        pool_n = $urandom_range(2, 8);
        for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
        graph_nodes = $urandom_range(1, 10);
        queue_item(csac_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 8'($urandom));
        for (int n = 0; n < graph_nodes; n++) begin
            if ($urandom_range(99) < 5) queue_noise();
            // occasionally an out-of-order id
            if ($urandom_range(99) < 6)
                queue_item(csac_pkg::OP_ADD_NODE, 8'(n + $urandom_range(1, 255)),
                           16'($urandom), 8'($urandom));
            queue_item(csac_pkg::OP_ADD_NODE, 8'(n), 16'($urandom), 8'($urandom));
            fanout = $urandom_range(0, 6);
            for (int e = 0; e < fanout; e++) begin
                roll = $urandom_range(99);
                if (roll < 85) dest = 8'($urandom_range(0, graph_nodes - 1));
                else dest = 8'($urandom);
                queue_item(csac_pkg::OP_ADD_EDGE, 8'($urandom),
                           pool[$urandom_range(0, pool_n - 1)], dest);
            end
        end
        if ($urandom_range(99) < 10) queue_item(csac_pkg::OP_TRANSITION, 8'($urandom),
                                                pool[0], 8'($urandom));
        queue_item(csac_pkg::OP_FINALIZE, 8'($urandom), 16'($urandom), 8'($urandom));
        steps = $urandom_range(5, 30);
        for (int s = 0; s < steps; s++) begin
            roll = $urandom_range(99);
            if (roll < 75)
                queue_item(csac_pkg::OP_TRANSITION, 8'($urandom),
                           pool[$urandom_range(0, pool_n - 1)], 8'($urandom));
            else if (roll < 85)
                queue_item(csac_pkg::OP_TRANSITION, 8'($urandom), 16'($urandom),
                           8'($urandom));
            else if (roll < 92)
                queue_item(csac_pkg::OP_RESET, 8'($urandom), 16'($urandom), 8'($urandom));
            else
                queue_noise();
        end
    endtask

    // loads every node slot, then overflows the node table
    task automatic queue_table_fill();
        logic [csac_pkg::CALL_ID_BITS-1:0] pool [16];
        int room;
        int fanout;
        for (int i = 0; i < 16; i++) pool[i] = 16'($urandom);
        room = csac_pkg::MAX_EDGES;
        queue_item(csac_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 8'($urandom), 1'b1);
        for (int n = 0; n < csac_pkg::MAX_NODES; n++) begin
            queue_item(csac_pkg::OP_ADD_NODE, 8'(n), 16'($urandom), 8'($urandom));
            if (n == 0) fanout = 16;
            else fanout = $urandom_range(0, 1);
            if (fanout > room) fanout = room;
            room -= fanout;
            for (int e = 0; e < fanout; e++)
                queue_item(csac_pkg::OP_ADD_EDGE, 8'($urandom), pool[$urandom_range(0, 15)],
                           8'($urandom));
        end
        queue_item(csac_pkg::OP_ADD_EDGE, 8'($urandom), 16'($urandom), 8'($urandom));
        queue_item(csac_pkg::OP_ADD_NODE, 8'($urandom), 16'($urandom), 8'($urandom));
        queue_item(csac_pkg::OP_FINALIZE, 8'($urandom), 16'($urandom), 8'($urandom));
        for (int s = 0; s < 40; s++) begin
            if ($urandom_range(99) < 10)
                queue_item(csac_pkg::OP_RESET, 8'($urandom), 16'($urandom), 8'($urandom));
            else
                queue_item(csac_pkg::OP_TRANSITION, 8'($urandom), pool[$urandom_range(0, 15)],
                           8'($urandom));
        end
    endtask

    initial begin
        // directed corner cases
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_RESET, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'h00, 16'h1111, 8'h01);
        queue_item(csac_pkg::OP_ADD_NODE, 8'hFF, 16'hFFFF, 8'hFF);
        queue_item(csac_pkg::OP_ADD_NODE, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'hFF, 16'hFFFF, 8'h01);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'h00, 16'h1234, 8'hFF);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'h00, 16'hFFFF, 8'h02);
        queue_item(csac_pkg::OP_ADD_NODE, 8'h01, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_FINALIZE, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_FINALIZE, 8'hFF, 16'hFFFF, 8'hFF);
        queue_item(csac_pkg::OP_ADD_NODE, 8'h02, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_ADD_EDGE, 8'h00, 16'h2222, 8'h01);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'h5555, 8'h00);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'hFFFF, 8'h00);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'hFFFF, 8'h00);
        queue_item(csac_pkg::OP_RESET, 8'hFF, 16'hFFFF, 8'hFF);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'h1234, 8'h00);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'h1234, 8'h00);
        queue_item(OP_SPARE_A, 8'hFF, 16'hFFFF, 8'hFF);
        queue_item(OP_SPARE_B, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 8'hFF);
        queue_item(csac_pkg::OP_FINALIZE, 8'h00, 16'h0000, 8'h00);
        queue_item(csac_pkg::OP_TRANSITION, 8'h00, 16'hFFFF, 8'h00);
        // random sessions, with the full-table pass in the middle
        while (n_queued < FIRST_ITEMS) queue_session();
        queue_table_fill();
        queue_item(csac_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 8'($urandom), 1'b1);
        while (n_queued < TOTAL_ITEMS) queue_session();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (results_seen < n_queued) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        t_call_item it;
        bit busy;
        int sent_now;
        if (i_rst_n) begin
            busy = in_valid;
            sent_now = items_sent;
            if (in_valid && in_ready) begin
                it.opcode = opcode;
                it.node_id = node_id;
                it.call_id = call_id;
                it.next_state = next_state;
                it.hold = 1'b0;
                verdict_q.push_back(advance_automaton(it));
                sent_now = items_sent + 1;
                items_sent <= sent_now;
                busy = 1'b0;
            end
            if (!busy) begin
                if (call_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                    && (!call_q[0].hold || sent_now == results_seen)) begin
                    it = call_q.pop_front();
                    opcode <= it.opcode;
                    node_id <= it.node_id;
                    call_id <= it.call_id;
                    next_state <= it.next_state;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (out_valid && out_ready) begin
                if (results_seen >= items_sent) begin
                    report_mismatch($sformatf("unexpected result status %0d node %0d",
                                              status, current_state));
                end else begin
                    want = verdict_q.pop_front();
                    results_seen <= results_seen + 1;
                    if (status !== want.status)
                        report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                                  results_seen, status, want.status));
                    if (current_state !== want.node)
                        report_mismatch($sformatf("item %0d node %0d, expected %0d",
                                                  results_seen, current_state, want.node));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[filelist.f]
sv/csac_pkg.sv
sv/csac_ctrl.sv
sv/csac_dp.sv
sv/call_sequence_automaton_checker.sv
test/tb_call_sequence_automaton_checker.sv
